// File: hdl/piecewise_linear_delay_profile_defines.svh
// Assertion macros for the piecewise linear delay profile block.
`ifndef PIECEWISE_LINEAR_DELAY_PROFILE_DEFINES_SVH
`define PIECEWISE_LINEAR_DELAY_PROFILE_DEFINES_SVH
`ifndef SYNTHESIS
`define PLDP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PLDP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PLDP_ASSERT(label, clk, rst_n, prop)
`define PLDP_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: hdl/pldp_pkg.sv
// Shared types and constants of the piecewise linear delay profile block.
`timescale 1ns / 1ps
package pldp_pkg;
  localparam int TableDepth = 64;
  localparam int DelayBits  = 16;
  localparam int TimeBits   = 32;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = $clog2(TableDepth + 1);
  localparam int ProdBits   = DelayBits + TimeBits;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef enum logic [3:0] {
    CmdNone, CmdClrMax, CmdRdA, CmdRdB, CmdShift, CmdWrNew, CmdWrOver,
    CmdMaxAcc, CmdLoadDiv, CmdDivStep, CmdMulStep, CmdSetRes, CmdTickZero
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IdxBits-1:0] addr;
    logic [1:0]        res_sel; // 0 zero, 1 mem delay, 2 interp
  } pldp_cmd_t;

  typedef struct packed {
    logic              time_ge;   // read time >= key
    logic              time_eq;   // read time == key
    logic              div_done;
    logic              mul_done;
  } pldp_stat_t;

  localparam logic [1:0] ResZero   = 2'd0;
  localparam logic [1:0] ResMem    = 2'd1;
  localparam logic [1:0] ResInterp = 2'd2;
endpackage

// File: hdl/pldp_datapath.sv
// Datapath: breakpoint memory, tick counter, serial multiplier and divider.
`timescale 1ns / 1ps
module pldp_datapath import pldp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pldp_cmd_t            cmd_i,
  input  logic [TimeBits-1:0]  key_i,
  input  logic [DelayBits-1:0] new_delay_i,
  input  logic                 tick_inc_i,
  output pldp_stat_t           stat_o,
  output logic [TimeBits-1:0]  tick_o,
  output logic [DelayBits-1:0] max_o,
  output logic [DelayBits-1:0] res_o
);
  logic [TimeBits-1:0]  time_mem [TableDepth];
  logic [DelayBits-1:0] dly_mem  [TableDepth];
  logic [TimeBits-1:0]  rt_q;
  logic [DelayBits-1:0] rd_q;
  logic [TimeBits-1:0]  t0_q;
  logic [DelayBits-1:0] d0_q;
  logic [TimeBits-1:0]  tick_q;
  logic [DelayBits-1:0] max_q, res_q;
  logic [ProdBits-1:0]  prod_q, mcand_q;
  logic [TimeBits-1:0]  mplier_q;
  logic [TimeBits:0]    rem_q;
  logic [TimeBits-1:0]  span_q;
  logic [ProdBits-1:0]  quo_q;
  logic [6:0]           step_q;
  logic                 down_q;
  logic [TimeBits:0]    rem_sh;
  logic [DelayBits:0]   interp;

  // Memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cmd)
      CmdShift: begin
        time_mem[cmd_i.addr] <= rt_q;
        dly_mem[cmd_i.addr]  <= rd_q;
      end
      CmdWrNew: begin
        time_mem[cmd_i.addr] <= key_i;
        dly_mem[cmd_i.addr]  <= new_delay_i;
      end
      CmdWrOver: dly_mem[cmd_i.addr] <= new_delay_i;
      default: ;
    endcase
    if (cmd_i.cmd == CmdRdA || cmd_i.cmd == CmdRdB) begin
      rt_q <= time_mem[cmd_i.addr];
      rd_q <= dly_mem[cmd_i.addr];
    end
    if (cmd_i.cmd == CmdRdB) begin
      t0_q <= rt_q;
      d0_q <= rd_q;
    end
  end

  assign rem_sh = {rem_q[TimeBits-1:0], quo_q[ProdBits-1]};
  assign interp = down_q ? {1'b0, d0_q} - {1'b0, quo_q[DelayBits-1:0]}
                         : {1'b0, d0_q} + {1'b0, quo_q[DelayBits-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      max_q    <= '0;
      step_q   <= '0;
      down_q   <= 1'b0;
      mcand_q  <= '0;
      mplier_q <= '0;
      span_q   <= '0;
      prod_q   <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
    end else begin
      if (tick_inc_i) tick_q <= tick_q + 1'b1;
      unique case (cmd_i.cmd) inside
        // An overwrite clears the maximum too, so the rescan can lower it.
        CmdClrMax, CmdWrOver: max_q <= '0;
        CmdMaxAcc:   if (rd_q > max_q) max_q <= rd_q;
        CmdTickZero: tick_q <= '0;
        CmdLoadDiv: begin
          // rt_q holds t1, t0_q/d0_q the predecessor.
          down_q   <= rd_q < d0_q;
          mcand_q  <= ProdBits'(rd_q < d0_q ? d0_q - rd_q : rd_q - d0_q);
          mplier_q <= tick_q - t0_q;
          span_q   <= rt_q - t0_q;
          prod_q   <= '0;
          step_q   <= '0;
        end
        CmdMulStep: begin
          if (mplier_q[0]) prod_q <= prod_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          if (step_q == 7'(TimeBits - 1)) begin
            step_q <= '0;
            rem_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        CmdDivStep: begin
          if (step_q == 7'd0) quo_q <= prod_q + (mplier_q[0] ? mcand_q : '0);
          else begin
            if (rem_sh >= {1'b0, span_q}) begin
              rem_q <= rem_sh - {1'b0, span_q};
              quo_q <= {quo_q[ProdBits-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[ProdBits-2:0], 1'b0};
            end
          end
          step_q <= step_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CmdSetRes) begin
      unique case (cmd_i.res_sel)
        ResMem:    res_q <= rd_q;
        ResInterp: res_q <= interp[DelayBits-1:0];
        default:   res_q <= '0;
      endcase
    end
  end

  assign stat_o.time_ge  = rt_q >= key_i;
  assign stat_o.time_eq  = rt_q == key_i;
  assign stat_o.mul_done = step_q == 7'(TimeBits - 1);
  assign stat_o.div_done = step_q == 7'(ProdBits);
  assign tick_o = tick_q;
  assign max_o  = max_q;
  assign res_o  = res_q;
endmodule

// File: hdl/pldp_ctrl.sv
// Controller: sequences table search, insert shift, max rescan and interpolation.
`timescale 1ns / 1ps
`include "piecewise_linear_delay_profile_defines.svh"
module pldp_ctrl import pldp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic                 loop_mode_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [CntBits-1:0]   count_o,
  output logic [1:0]           status_o,
  input  pldp_stat_t           stat_i,
  output pldp_cmd_t            cmd_o,
  output logic                 tick_inc_o
);
  typedef enum logic [3:0] {
    SIdle, SSearchRd, SSearchCmp, SIns, SShiftRd, SShiftWr, SWrNew,
    SMaxRd, SMaxAcc, STickHit, SInterpRd, SInterp, SMul, SDiv, SFin, SOut
  } state_e;

  state_e             state_q;
  logic [CntBits-1:0] cnt_q, idx_q, sh_q;
  logic               op_q;
  logic [1:0]         status_q, res_sel_q;
  logic               out_valid_q;

  assign in_ready_o  = state_q == SIdle && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign count_o     = cnt_q;
  assign status_o    = status_q;
  assign tick_inc_o  = in_valid_i && in_ready_o && opcode_i;

  always_comb begin
    cmd_o = '{cmd: CmdNone, addr: idx_q[IdxBits-1:0], res_sel: res_sel_q};
    unique case (state_q)
      SSearchRd: cmd_o.cmd = CmdRdA;
      SShiftRd: begin
        cmd_o.cmd  = CmdRdA;
        cmd_o.addr = IdxBits'(sh_q - 1'b1);
      end
      SShiftWr: begin
        cmd_o.cmd  = CmdShift;
        cmd_o.addr = sh_q[IdxBits-1:0];
      end
      SWrNew:   cmd_o.cmd = CmdWrNew;
      SIns: begin
        // Drop on a full table leaves the maximum untouched.
        if (stat_i.time_eq && idx_q < cnt_q) cmd_o.cmd = CmdWrOver;
        else if (cnt_q != CntBits'(TableDepth)) cmd_o.cmd = CmdClrMax;
      end
      SMaxRd: begin
        cmd_o.cmd  = CmdRdA;
        cmd_o.addr = sh_q[IdxBits-1:0];
      end
      SMaxAcc:  cmd_o.cmd = CmdMaxAcc;
      STickHit: begin
        // Past the end in loop mode restart the counter; before an
        // interpolation fetch the predecessor first.
        if (idx_q == cnt_q && loop_mode_i) begin
          cmd_o.cmd = CmdTickZero;
        end else begin
          cmd_o.cmd = CmdRdA;
          if (idx_q != '0 && idx_q != cnt_q) cmd_o.addr = IdxBits'(idx_q - 1'b1);
        end
      end
      SInterpRd: begin
        cmd_o.cmd  = CmdRdB;
        cmd_o.addr = idx_q[IdxBits-1:0];
      end
      SInterp:  cmd_o.cmd = CmdLoadDiv;
      SMul:     cmd_o.cmd = CmdMulStep;
      SDiv:     cmd_o.cmd = CmdDivStep;
      SFin:     cmd_o.cmd = CmdSetRes;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      sh_q        <= '0;
      op_q        <= 1'b0;
      status_q    <= StatusOk;
      res_sel_q   <= ResZero;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
          if (in_valid_i && in_ready_o) begin
            op_q      <= opcode_i;
            idx_q     <= '0;
            res_sel_q <= ResZero;
            if (opcode_i && cnt_q == '0) begin
              status_q <= StatusEmpty;
              state_q  <= SFin;
            end else if (cnt_q == '0) begin
              status_q <= StatusOk;
              state_q  <= SIns;
            end else begin
              status_q <= StatusOk;
              state_q  <= SSearchRd;
            end
          end
        end
        SSearchRd: state_q <= SSearchCmp;
        SSearchCmp: begin
          if (stat_i.time_ge) begin
            state_q <= op_q ? STickHit : SIns;
          end else if (idx_q + 1'b1 == cnt_q) begin
            idx_q   <= cnt_q;
            state_q <= op_q ? STickHit : SIns;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= SSearchRd;
          end
        end
        SIns: begin
          if (stat_i.time_eq && idx_q < cnt_q) begin
            sh_q    <= '0;
            state_q <= SMaxRd;
          end else if (cnt_q == CntBits'(TableDepth)) begin
            status_q <= StatusFull;
            state_q  <= SFin;
          end else if (cnt_q == idx_q) begin
            state_q <= SWrNew;
          end else begin
            sh_q    <= cnt_q;
            state_q <= SShiftRd;
          end
        end
        SShiftRd: state_q <= SShiftWr;
        SShiftWr: begin
          sh_q    <= sh_q - 1'b1;
          state_q <= (sh_q - 1'b1 == idx_q) ? SWrNew : SShiftRd;
        end
        SWrNew: begin
          cnt_q   <= cnt_q + 1'b1;
          sh_q    <= '0;
          state_q <= SMaxRd;
        end
        SMaxRd: state_q <= SMaxAcc;
        SMaxAcc: begin
          sh_q    <= sh_q + 1'b1;
          state_q <= (sh_q + 1'b1 == cnt_q) ? SFin : SMaxRd;
        end
        STickHit: begin
          // Read issued at idx_q, or at idx_q - 1 before an interpolation; past end read last or first entry.
          if (idx_q == cnt_q) begin
            res_sel_q <= ResMem;
            if (loop_mode_i) idx_q <= '0;
            else idx_q <= cnt_q - 1'b1;
            state_q <= SInterpRd;
          end else if (idx_q == '0) begin
            res_sel_q <= ResMem;
            state_q   <= SFin;
          end else begin
            res_sel_q <= ResInterp;
            state_q   <= SInterpRd;
          end
        end
        SInterpRd: begin
          if (res_sel_q == ResMem) begin
            state_q <= SFin;
          end else begin
            state_q <= SInterp;
          end
        end
        SInterp: state_q <= SMul;
        SMul:    if (stat_i.mul_done) state_q <= SDiv;
        SDiv:    if (stat_i.div_done) state_q <= SFin;
        SFin: begin
          out_valid_q <= 1'b1;
          state_q     <= SOut;
        end
        SOut: begin
          if (out_ready_i) out_valid_q <= 1'b0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `PLDP_ASSERT(a_count_range, clk_i, rst_ni, cnt_q <= CntBits'(TableDepth))
  `PLDP_ASSERT(a_no_accept_busy, clk_i, rst_ni, state_q != SIdle |-> !in_ready_o)
  `PLDP_ASSERT(a_full_no_grow, clk_i, rst_ni,
    (state_q == SIns && status_q == StatusOk && cnt_q == CntBits'(TableDepth))
    |=> cnt_q == CntBits'(TableDepth))
endmodule

// File: hdl/piecewise_linear_delay_profile.sv
// Top level of the piecewise linear delay profile block.
`timescale 1ns / 1ps
// Piecewise linear delay profile: holds up to 64 sorted breakpoints (time,
// delay). Opcode 0 inserts or overwrites a breakpoint, opcode 1 advances the
// tick counter and returns the delay interpolated between neighboring
// breakpoints, the offset from the earlier one truncated toward zero. Loop
// mode, written through cfg_we_i and cfg_wdata_i, restarts the profile and
// clears the tick counter after the last breakpoint. One item at a time: a
// tick takes a linear table search and, to interpolate, 32 multiply steps
// and 49 divide steps of the shared serial unit; an insert takes the search,
// a shift of each entry that it moves and a rescan of the maximum. The
// single-port breakpoint memory makes the search, shift and rescan serial.
// The result beat is held in an output register until taken.
`include "piecewise_linear_delay_profile_defines.svh"
module piecewise_linear_delay_profile import pldp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // entry_time[31:0], entry_delay[47:32], zero pad
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // delay_ms, max_delay_ms, entry_count, status, pad
);
  logic                 loop_mode_q;
  logic [TimeBits-1:0]  key_q, tick;
  logic [DelayBits-1:0] dly_q, max_d, res;
  logic [CntBits-1:0]   cnt;
  logic [1:0]           status;
  logic                 tick_inc, accept;
  pldp_cmd_t            cmd;
  pldp_stat_t           stat;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Hold the config bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) loop_mode_q <= 1'b0;
    else if (cfg_we_i) loop_mode_q <= cfg_wdata_i;
  end

  // Capture insert payload; for a tick the search key is the new tick value.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= s_axis_tuser ? tick + 1'b1 : s_axis_tdata[31:0];
      dly_q <= s_axis_tdata[47:32];
    end
  end

  pldp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .loop_mode_i(loop_mode_q),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .count_o    (cnt),
    .status_o   (status),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .tick_inc_o (tick_inc)
  );

  pldp_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .key_i      (key_q),
    .new_delay_i(dly_q),
    .tick_inc_i (tick_inc),
    .stat_o     (stat),
    .tick_o     (tick),
    .max_o      (max_d),
    .res_o      (res)
  );

  assign m_axis_tdata = {7'd0, status, cnt, max_d, res};

  `PLDP_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `PLDP_ASSERT(a_out_stable, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `PLDP_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tdata[47:41] == 7'd0)
endmodule
